// File: hdl/dlr_pkg.sv
// Shared types and constants for the DDA line rasterizer with scale and rotate.
// Used by every module of the block; no dependencies of its own.
`default_nettype none

package dlr_pkg;

  // Configuration port geometry
  localparam int ADDR_W    = 5;
  localparam int DATA_W    = 32;
  localparam int REG_IDX_W = ADDR_W - 2;
  localparam int CFG_W     = 16;
  localparam int COLOUR_W  = 4;

  // Register indexes (byte address = 4 * index)
  localparam logic [REG_IDX_W-1:0] REG_SCALE_X      = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_SCALE_Y      = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_COS_ANGLE    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_SIN_ANGLE    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_PIXEL_COLOUR = 3'd4;

  // Reset values: unit scale, zero angle, white
  localparam logic [CFG_W-1:0]    RST_SCALE  = 16'h1000;
  localparam logic [CFG_W-1:0]    RST_COS    = 16'h4000;
  localparam logic [CFG_W-1:0]    RST_SIN    = 16'h0000;
  localparam logic [COLOUR_W-1:0] RST_COLOUR = 4'hF;

  // Fraction bits of the scale (Q4.12) and rotation (Q1.14) factors
  localparam int SCALE_SHIFT = 12;
  localparam int ROT_SHIFT   = 14;

  typedef struct packed {
    logic [CFG_W-1:0]    scale_x;
    logic [CFG_W-1:0]    scale_y;
    logic [CFG_W-1:0]    cos_angle;
    logic [CFG_W-1:0]    sin_angle;
    logic [COLOUR_W-1:0] pixel_colour;
  } dlr_cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCALE,
    ST_ROTATE,
    ST_COMBINE,
    ST_DELTA,
    ST_DIVIDE,
    ST_FINISH
  } dlr_state_t;

  // Controller to datapath
  typedef struct packed {
    logic take_load;
    logic advance;
    logic scale;
    logic rotate;
    logic combine;
    logic point;
    logic delta;
    logic div_first;
    logic div_step;
    logic finish;
  } dlr_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic active;
    logic out_busy;
  } dlr_status_t;

endpackage

`default_nettype wire

// File: hdl/dlr_if.sv
// Valid/ready channel interfaces: command requests in, pixel requests out.
// Coordinate payload widths follow COORD_BITS; uses no package.
`default_nettype none

interface dlr_cmd_if #(parameter int COORD_BITS = 12);
  logic                         valid;
  logic                         ready;
  logic                         command;
  logic signed [COORD_BITS-1:0] start_x;
  logic signed [COORD_BITS-1:0] start_y;
  logic signed [COORD_BITS-1:0] end_x;
  logic signed [COORD_BITS-1:0] end_y;

  modport source (output valid, command, start_x, start_y, end_x, end_y, input ready);
  modport sink   (input valid, command, start_x, start_y, end_x, end_y, output ready);
endinterface

interface dlr_pix_if #(parameter int COORD_BITS = 12);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] pixel_x;
  logic signed [COORD_BITS-1:0] pixel_y;
  logic [3:0]                   colour;
  logic                         last;

  modport source (output valid, pixel_x, pixel_y, colour, last, input ready);
  modport sink   (input valid, pixel_x, pixel_y, colour, last, output ready);
endinterface

`default_nettype wire

// File: hdl/dlr_regs.sv
// APB-style configuration registers: scale, rotation and colour.
// Depends on dlr_pkg.
`default_nettype none

module dlr_regs (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [dlr_pkg::ADDR_W-1:0]    paddr,
  input  wire logic [dlr_pkg::DATA_W-1:0]    pwdata,
  output logic      [dlr_pkg::DATA_W-1:0]    prdata,
  output logic                               pready,
  output dlr_pkg::dlr_cfg_t                  cfg
);

  logic [dlr_pkg::REG_IDX_W-1:0] idx;
  logic                          wr;

  assign idx    = paddr[dlr_pkg::ADDR_W-1:2];
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;

  // Register writes in the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.scale_x      <= dlr_pkg::RST_SCALE;
      cfg.scale_y      <= dlr_pkg::RST_SCALE;
      cfg.cos_angle    <= dlr_pkg::RST_COS;
      cfg.sin_angle    <= dlr_pkg::RST_SIN;
      cfg.pixel_colour <= dlr_pkg::RST_COLOUR;
    end else if (wr) begin
      case (idx)
        dlr_pkg::REG_SCALE_X:      cfg.scale_x      <= pwdata[dlr_pkg::CFG_W-1:0];
        dlr_pkg::REG_SCALE_Y:      cfg.scale_y      <= pwdata[dlr_pkg::CFG_W-1:0];
        dlr_pkg::REG_COS_ANGLE:    cfg.cos_angle    <= pwdata[dlr_pkg::CFG_W-1:0];
        dlr_pkg::REG_SIN_ANGLE:    cfg.sin_angle    <= pwdata[dlr_pkg::CFG_W-1:0];
        dlr_pkg::REG_PIXEL_COLOUR: cfg.pixel_colour <= pwdata[dlr_pkg::COLOUR_W-1:0];
        default: ;
      endcase
    end
  end

  // Read mux, zero extended
  always_comb begin
    case (idx)
      dlr_pkg::REG_SCALE_X:
        prdata = {{(dlr_pkg::DATA_W-dlr_pkg::CFG_W){1'b0}}, cfg.scale_x};
      dlr_pkg::REG_SCALE_Y:
        prdata = {{(dlr_pkg::DATA_W-dlr_pkg::CFG_W){1'b0}}, cfg.scale_y};
      dlr_pkg::REG_COS_ANGLE:
        prdata = {{(dlr_pkg::DATA_W-dlr_pkg::CFG_W){1'b0}}, cfg.cos_angle};
      dlr_pkg::REG_SIN_ANGLE:
        prdata = {{(dlr_pkg::DATA_W-dlr_pkg::CFG_W){1'b0}}, cfg.sin_angle};
      dlr_pkg::REG_PIXEL_COLOUR:
        prdata = {{(dlr_pkg::DATA_W-dlr_pkg::COLOUR_W){1'b0}}, cfg.pixel_colour};
      default:
        prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// File: hdl/dlr_ctrl.sv
// Sequencer for the line engine: load transform, DDA setup, divide, advance.
// Depends on dlr_pkg; drives dlr_datapath through a command struct.
`default_nettype none

module dlr_ctrl #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 req_valid,
  input  wire logic                 req_command,
  input  wire dlr_pkg::dlr_status_t sts,
  output logic                      ready,
  output dlr_pkg::dlr_cmd_t         ctl
);

  localparam int DCW = $clog2(FRAC_BITS + 1);
  localparam logic [DCW-1:0] DIV_LAST = DCW'(FRAC_BITS);
  localparam logic [DCW-1:0] DIV_ONE  = {{(DCW-1){1'b0}}, 1'b1};

  dlr_pkg::dlr_state_t state, state_next;
  logic                point, point_next;
  logic [DCW-1:0]      div_cnt, div_cnt_next;
  logic                accept;

  // New requests only in idle, and only once the pixel slot can take one
  assign ready  = (state == dlr_pkg::ST_IDLE) && !sts.out_busy;
  assign accept = req_valid && ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= dlr_pkg::ST_IDLE;
      point   <= 1'b0;
      div_cnt <= '0;
    end else begin
      state   <= state_next;
      point   <= point_next;
      div_cnt <= div_cnt_next;
    end
  end

  // Next state
  always_comb begin
    state_next   = state;
    point_next   = point;
    div_cnt_next = div_cnt;
    case (state)
      dlr_pkg::ST_IDLE: begin
        if (accept && !req_command) begin
          state_next = dlr_pkg::ST_SCALE;
          point_next = 1'b0;
        end
      end
      dlr_pkg::ST_SCALE:  state_next = dlr_pkg::ST_ROTATE;
      dlr_pkg::ST_ROTATE: state_next = dlr_pkg::ST_COMBINE;
      dlr_pkg::ST_COMBINE: begin
        if (point) begin
          state_next = dlr_pkg::ST_DELTA;
        end else begin
          point_next = 1'b1;
          state_next = dlr_pkg::ST_SCALE;
        end
      end
      dlr_pkg::ST_DELTA: begin
        div_cnt_next = '0;
        state_next   = dlr_pkg::ST_DIVIDE;
      end
      dlr_pkg::ST_DIVIDE: begin
        if (div_cnt == DIV_LAST) begin
          state_next = dlr_pkg::ST_FINISH;
        end else begin
          div_cnt_next = div_cnt + DIV_ONE;
        end
      end
      dlr_pkg::ST_FINISH: state_next = dlr_pkg::ST_IDLE;
      default:            state_next = dlr_pkg::ST_IDLE;
    endcase
  end

  // Datapath commands
  always_comb begin
    ctl       = '0;
    ctl.point = point;
    case (state)
      dlr_pkg::ST_IDLE: begin
        ctl.take_load = accept && !req_command;
        ctl.advance   = accept && req_command && sts.active;
      end
      dlr_pkg::ST_SCALE:   ctl.scale   = 1'b1;
      dlr_pkg::ST_ROTATE:  ctl.rotate  = 1'b1;
      dlr_pkg::ST_COMBINE: ctl.combine = 1'b1;
      dlr_pkg::ST_DELTA:   ctl.delta   = 1'b1;
      dlr_pkg::ST_DIVIDE: begin
        ctl.div_first = (div_cnt == '0);
        ctl.div_step  = (div_cnt != '0);
      end
      dlr_pkg::ST_FINISH:  ctl.finish  = 1'b1;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// File: hdl/dlr_datapath.sv
// Datapath: endpoint transform, DDA setup with bit-serial divide, accumulators
// and the pixel output register. Depends on dlr_pkg; steered by dlr_ctrl.
`default_nettype none

module dlr_datapath #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire dlr_pkg::dlr_cmd_t             ctl,
  output dlr_pkg::dlr_status_t               sts,
  input  wire dlr_pkg::dlr_cfg_t             cfg,
  input  wire logic signed [COORD_BITS-1:0]  start_x,
  input  wire logic signed [COORD_BITS-1:0]  start_y,
  input  wire logic signed [COORD_BITS-1:0]  end_x,
  input  wire logic signed [COORD_BITS-1:0]  end_y,
  input  wire logic                          out_ready,
  output logic                               out_valid,
  output logic signed [COORD_BITS-1:0]       pixel_x,
  output logic signed [COORD_BITS-1:0]       pixel_y,
  output logic [dlr_pkg::COLOUR_W-1:0]       colour,
  output logic                               last
);

  localparam int C  = COORD_BITS;
  localparam int F  = FRAC_BITS;
  localparam int MW = C + dlr_pkg::CFG_W + 1;      // coord * scale
  localparam int SW = MW - dlr_pkg::SCALE_SHIFT;   // scaled coord
  localparam int PW = SW + dlr_pkg::CFG_W;         // scaled * cos/sin
  localparam int RW = PW + 1;                      // rotation sum
  localparam int QW = RW - dlr_pkg::ROT_SHIFT;     // rotated, before saturation
  localparam int AW = C + F + 1;                   // accumulator
  localparam int IW = F + 2;                       // increment

  // Saturate a rotated value to the coordinate range
  function automatic logic [C-1:0] sat_coord(input logic [QW-1:0] v);
    logic fits;
    fits = (v[QW-1:C-1] == {(QW-C+1){v[QW-1]}});
    return fits ? v[C-1:0] : {v[QW-1], {(C-1){~v[QW-1]}}};
  endfunction

  // Latched endpoints
  logic signed [C-1:0] ld_sx, ld_sy, ld_ex, ld_ey;
  always_ff @(posedge clk) begin
    if (ctl.take_load) begin
      ld_sx <= start_x;
      ld_sy <= start_y;
      ld_ex <= end_x;
      ld_ey <= end_y;
    end
  end

  // Scale stage: per-axis multiply, truncate toward zero
  logic signed [C-1:0]  px, py;
  logic signed [MW-1:0] mx, my;
  logic [MW-1:0]        mxb, myb;
  logic signed [SW-1:0] scl_x, scl_y;

  assign px  = ctl.point ? ld_ex : ld_sx;
  assign py  = ctl.point ? ld_ey : ld_sy;
  assign mx  = px * $signed({1'b0, cfg.scale_x});
  assign my  = py * $signed({1'b0, cfg.scale_y});
  assign mxb = mx + {{(MW-dlr_pkg::SCALE_SHIFT){1'b0}}, {dlr_pkg::SCALE_SHIFT{mx[MW-1]}}};
  assign myb = my + {{(MW-dlr_pkg::SCALE_SHIFT){1'b0}}, {dlr_pkg::SCALE_SHIFT{my[MW-1]}}};

  always_ff @(posedge clk) begin
    if (ctl.scale) begin
      scl_x <= mxb[MW-1:dlr_pkg::SCALE_SHIFT];
      scl_y <= myb[MW-1:dlr_pkg::SCALE_SHIFT];
    end
  end

  // Rotate stage: four products
  logic signed [PW-1:0] p_xc, p_ys, p_xs, p_yc;
  always_ff @(posedge clk) begin
    if (ctl.rotate) begin
      p_xc <= scl_x * $signed(cfg.cos_angle);
      p_ys <= scl_y * $signed(cfg.sin_angle);
      p_xs <= scl_x * $signed(cfg.sin_angle);
      p_yc <= scl_y * $signed(cfg.cos_angle);
    end
  end

  // Combine stage: sum, truncate toward zero, saturate
  logic signed [RW-1:0] rx, ry;
  logic [RW-1:0]        rxb, ryb;
  logic signed [C-1:0]  x0, y0, x1, y1;

  assign rx  = p_xc - p_ys;
  assign ry  = p_xs + p_yc;
  assign rxb = rx + {{(RW-dlr_pkg::ROT_SHIFT){1'b0}}, {dlr_pkg::ROT_SHIFT{rx[RW-1]}}};
  assign ryb = ry + {{(RW-dlr_pkg::ROT_SHIFT){1'b0}}, {dlr_pkg::ROT_SHIFT{ry[RW-1]}}};

  always_ff @(posedge clk) begin
    if (ctl.combine) begin
      if (ctl.point) begin
        x1 <= sat_coord(rxb[RW-1:dlr_pkg::ROT_SHIFT]);
        y1 <= sat_coord(ryb[RW-1:dlr_pkg::ROT_SHIFT]);
      end else begin
        x0 <= sat_coord(rxb[RW-1:dlr_pkg::ROT_SHIFT]);
        y0 <= sat_coord(ryb[RW-1:dlr_pkg::ROT_SHIFT]);
      end
    end
  end

  // Delta stage: magnitudes, signs and step count
  logic signed [C:0] dx, dy;
  logic [C:0]        ndx, ndy;
  logic [C-1:0]      adx_w, ady_w, steps_w;
  logic [C-1:0]      adx, ady, steps;
  logic              sgn_x, sgn_y;

  assign dx      = x1 - x0;
  assign dy      = y1 - y0;
  assign ndx     = ~dx + {{C{1'b0}}, 1'b1};
  assign ndy     = ~dy + {{C{1'b0}}, 1'b1};
  assign adx_w   = dx[C] ? ndx[C-1:0] : dx[C-1:0];
  assign ady_w   = dy[C] ? ndy[C-1:0] : dy[C-1:0];
  assign steps_w = (adx_w > ady_w) ? adx_w : ady_w;

  always_ff @(posedge clk) begin
    if (ctl.delta) begin
      adx   <= adx_w;
      ady   <= ady_w;
      steps <= steps_w;
      sgn_x <= dx[C];
      sgn_y <= dy[C];
    end
  end

  // Restoring divide, one quotient bit per cycle on each axis.
  // |delta| <= steps, so the integer part is a single bit.
  logic [C:0]   r_x, r_y, t_x, t_y;
  logic [F:0]   q_x, q_y;
  logic         ge0_x, ge0_y, ge_x, ge_y;

  assign ge0_x = adx >= steps;
  assign ge0_y = ady >= steps;
  assign t_x   = {r_x[C-1:0], 1'b0};
  assign t_y   = {r_y[C-1:0], 1'b0};
  assign ge_x  = t_x >= {1'b0, steps};
  assign ge_y  = t_y >= {1'b0, steps};

  always_ff @(posedge clk) begin
    if (ctl.div_first) begin
      r_x <= ge0_x ? {1'b0, adx - steps} : {1'b0, adx};
      r_y <= ge0_y ? {1'b0, ady - steps} : {1'b0, ady};
      q_x <= {{F{1'b0}}, ge0_x};
      q_y <= {{F{1'b0}}, ge0_y};
    end else if (ctl.div_step) begin
      r_x <= ge_x ? (t_x - {1'b0, steps}) : t_x;
      r_y <= ge_y ? (t_y - {1'b0, steps}) : t_y;
      q_x <= {q_x[F-1:0], ge_x};
      q_y <= {q_y[F-1:0], ge_y};
    end
  end

  // Signed increments from the quotients
  logic [IW-1:0] mag_x, mag_y, incv_x, incv_y;
  assign mag_x  = {1'b0, q_x};
  assign mag_y  = {1'b0, q_y};
  assign incv_x = sgn_x ? (~mag_x + {{(IW-1){1'b0}}, 1'b1}) : mag_x;
  assign incv_y = sgn_y ? (~mag_y + {{(IW-1){1'b0}}, 1'b1}) : mag_y;

  // DDA state: accumulators, increments, remaining pixels
  logic [AW-1:0] acc_x, acc_y;
  logic [IW-1:0] inc_x, inc_y;
  logic [C:0]    steps_left;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_x      <= '0;
      acc_y      <= '0;
      inc_x      <= '0;
      inc_y      <= '0;
      steps_left <= '0;
    end else begin
      if (ctl.delta) begin
        acc_x      <= {x0[C-1], x0, {F{1'b0}}};
        acc_y      <= {y0[C-1], y0, {F{1'b0}}};
        steps_left <= {1'b0, steps_w};
      end else if (ctl.advance) begin
        acc_x      <= acc_x + {{(AW-IW){inc_x[IW-1]}}, inc_x};
        acc_y      <= acc_y + {{(AW-IW){inc_y[IW-1]}}, inc_y};
        steps_left <= steps_left - {{C{1'b0}}, 1'b1};
      end
      if (ctl.finish) begin
        inc_x <= incv_x;
        inc_y <= incv_y;
      end
    end
  end

  // Integer part of the accumulators, truncated toward zero
  logic       rnd_x, rnd_y;
  logic [C:0] int_x, int_y;
  assign rnd_x = acc_x[AW-1] & (|acc_x[F-1:0]);
  assign rnd_y = acc_y[AW-1] & (|acc_y[F-1:0]);
  assign int_x = acc_x[AW-1:F] + {{C{1'b0}}, rnd_x};
  assign int_y = acc_y[AW-1:F] + {{C{1'b0}}, rnd_y};

  // Pixel output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.advance) begin
      pixel_x <= int_x[C-1:0];
      pixel_y <= int_y[C-1:0];
      colour  <= cfg.pixel_colour;
      last    <= (steps_left == {{C{1'b0}}, 1'b1});
    end
  end

  assign sts.active   = |steps_left;
  assign sts.out_busy = out_valid & ~out_ready;

endmodule

`default_nettype wire

// File: hdl/dda_line_rasterizer_scale_rotate_core.sv
// DDA line rasterizer with per-axis scale and rotation, top level.
// Channels: cmd (sink) takes requests; command 0 loads a line from start_x/y and
// end_x/y, command 1 advances one pixel. pixel (source) returns pixel_x/y, colour
// and last for each advance that has a pixel to give. The APB port sets scale_x,
// scale_y, cos_angle, sin_angle and pixel_colour at byte addresses 0,4,8,12,16.
// Load: both endpoints go through scale, rotate and combine steps, then the DDA
// setup divides each delta by the step count one quotient bit per cycle. A load
// keeps cmd.ready low from acceptance until the finish step is done and returns
// no pixel.
// Advance: the pixel sits in the output register the next cycle, and a
// new request is taken every cycle while pixel.ready stays high. An advance with
// no active line is consumed and returns nothing. The start point is drawn first;
// the end point is never drawn; a zero-length line draws nothing.
// Stall: while a pixel waits on pixel.ready low, cmd.ready is held low.
// Reset (rst, synchronous): no active line, registers to unit scale, zero angle,
// colour 15, output empty.
// Depends on dlr_pkg, dlr_if, dlr_regs, dlr_ctrl and dlr_datapath.
`default_nettype none

module dda_line_rasterizer_scale_rotate_core #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  dlr_cmd_if.sink                          cmd,
  dlr_pix_if.source                        pixel,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [dlr_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [dlr_pkg::DATA_W-1:0]  pwdata,
  output logic      [dlr_pkg::DATA_W-1:0]  prdata,
  output logic                             pready
);

  dlr_pkg::dlr_cfg_t    cfg;
  dlr_pkg::dlr_cmd_t    ctl;
  dlr_pkg::dlr_status_t sts;

  // Configuration registers
  dlr_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Sequencer
  dlr_ctrl #(
    .FRAC_BITS (FRAC_BITS)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (cmd.valid),
    .req_command (cmd.command),
    .sts         (sts),
    .ready       (cmd.ready),
    .ctl         (ctl)
  );

  // Arithmetic and pixel register
  dlr_datapath #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .sts       (sts),
    .cfg       (cfg),
    .start_x   (cmd.start_x),
    .start_y   (cmd.start_y),
    .end_x     (cmd.end_x),
    .end_y     (cmd.end_y),
    .out_ready (pixel.ready),
    .out_valid (pixel.valid),
    .pixel_x   (pixel.pixel_x),
    .pixel_y   (pixel.pixel_y),
    .colour    (pixel.colour),
    .last      (pixel.last)
  );

endmodule

`default_nettype wire
